// ===== rtl/lks_pkg.sv =====
// ----------------------------------------------------------------------------
// lks_pkg
// Shared types, codes and the lifecycle policy for the key selector.
// ----------------------------------------------------------------------------
package lks_pkg;

    // Table geometry
    localparam int MAX_KEYS  = 16;
    localparam int KEY_IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W     = KEY_IDX_W + 1;
    localparam int ID_W      = 32;
    localparam int TYPE_W    = 2;
    localparam int ENTRY_W   = ID_W + TYPE_W;
    localparam int RND_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int LIFE_W    = 3;
    localparam int CODE_W    = 8;
    localparam int VWORD_W   = 32;
    localparam int VWORDS    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Item kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Key types
    localparam logic [TYPE_W-1:0] KTYPE_TEST = 2'd0;
    localparam logic [TYPE_W-1:0] KTYPE_PROD = 2'd1;
    localparam logic [TYPE_W-1:0] KTYPE_DEV  = 2'd2;
    localparam logic [TYPE_W-1:0] KTYPE_BAD  = 2'd3;

    // Lifecycle states
    localparam logic [LIFE_W-1:0] LC_TEST     = 3'd0;
    localparam logic [LIFE_W-1:0] LC_PROD     = 3'd1;
    localparam logic [LIFE_W-1:0] LC_PROD_EOL = 3'd2;
    localparam logic [LIFE_W-1:0] LC_DEV      = 3'd3;
    localparam logic [LIFE_W-1:0] LC_RMA      = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAULT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALK_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIFE_STATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRUE_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_0    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_1    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_2    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_3    = 3'd7;

    // Reset values
    localparam logic [CNT_W-1:0]     KEY_COUNT_RST = CNT_W'(1);
    localparam logic [KEY_IDX_W-1:0] WALK_STEP_RST = KEY_IDX_W'(1);
    localparam logic [CODE_W-1:0]    TRUE_CODE_RST = 8'd165;

    typedef enum logic [1:0] {
        SEL_IDLE,
        SEL_WALK,
        SEL_DONE
    } sel_state_t;

    // Lifecycle policy for one matching entry: ok, refused or fault
    function automatic logic [STATUS_W-1:0] judge(
        input logic [TYPE_W-1:0] ktype,
        input logic [LIFE_W-1:0] life,
        input logic              otp_ok
    );
        logic [STATUS_W-1:0] verdict;
        verdict = ST_FAULT;
        if (ktype != KTYPE_BAD) begin
            unique case (life)
                LC_TEST:
                    verdict = (ktype == KTYPE_DEV) ? ST_BAD : ST_OK;
                LC_PROD, LC_PROD_EOL:
                    verdict = (ktype == KTYPE_PROD && otp_ok) ? ST_OK : ST_BAD;
                LC_DEV:
                    verdict = (ktype != KTYPE_TEST && otp_ok) ? ST_OK : ST_BAD;
                LC_RMA:
                    verdict = (ktype != KTYPE_DEV && otp_ok) ? ST_OK : ST_BAD;
                default:
                    verdict = ST_FAULT;
            endcase
        end
        return verdict;
    endfunction

endpackage

// ===== rtl/lifecycle_key_selector.sv =====
// ----------------------------------------------------------------------------
// lifecycle_key_selector
// Key table engine: stores key ids and types, and picks a key for a sought id
// by walking the table under the lifecycle policy.
// ----------------------------------------------------------------------------
// A write item stores one entry and yields no result. A lookup item walks n
// entries (n = key_count, capped at 16) from a start index set by the random
// word, reading one entry per cycle from the single-port key memory; its
// result passes from the walk through the done state into the output register;
// a fault ends the walk early, and a key count of zero skips the walk.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is taken.
module lifecycle_key_selector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [lks_pkg::KEY_IDX_W-1:0]     entry_index,
    input  logic [lks_pkg::ID_W-1:0]          key_id,
    input  logic [lks_pkg::TYPE_W-1:0]        key_class,
    input  logic [lks_pkg::RND_W-1:0]         random_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lks_pkg::STATUS_W-1:0]      status,
    output logic [lks_pkg::KEY_IDX_W-1:0]     chosen_index,
    input  logic                              cfg_wr_en,
    input  logic [lks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lks_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
    import lks_pkg::*;

    // Configuration registers
    logic [CNT_W-1:0]     key_count_reg;
    logic [KEY_IDX_W-1:0] walk_step_reg;
    logic [LIFE_W-1:0]    life_state_reg;
    logic [CODE_W-1:0]    true_code_reg;
    logic [VWORD_W-1:0]   valid_word_reg [VWORDS];

    // Key memory: type in the top bits, id below
    logic [ENTRY_W-1:0]   key_mem [MAX_KEYS];
    logic [ENTRY_W-1:0]   rdata_reg;

    // Control
    sel_state_t           state_reg, state_next;
    logic [KEY_IDX_W-1:0] addr_reg;
    logic [CNT_W-1:0]     remain_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [ID_W-1:0]      id_reg;
    logic                 p_vld_reg;
    logic [KEY_IDX_W-1:0] p_idx_reg;
    logic                 fault_reg;
    logic                 have_reg;
    logic [KEY_IDX_W-1:0] cand_reg;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [KEY_IDX_W-1:0] chosen_reg;

    logic                 accept;
    logic                 lookup_go;
    logic                 issue;
    logic                 load_out;
    logic                 walk_over;
    logic [CNT_W-1:0]     n_eff;
    logic [RND_W+CNT_W-1:0] start_prod;
    logic [KEY_IDX_W-1:0] start_idx;
    logic [CNT_W-1:0]     step_sum;
    logic [CNT_W-1:0]     step_wrap;
    logic                 step_bad;
    logic                 id_match;
    logic [CODE_W-1:0]    vbyte;
    logic [STATUS_W-1:0]  verdict;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg  <= KEY_COUNT_RST;
            walk_step_reg  <= WALK_STEP_RST;
            life_state_reg <= LC_TEST;
            true_code_reg  <= TRUE_CODE_RST;
            for (int w = 0; w < VWORDS; w++)
            begin
                valid_word_reg[w] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_KEY_COUNT:  key_count_reg     <= cfg_wdata[CNT_W-1:0];
                REG_WALK_STEP:  walk_step_reg     <= cfg_wdata[KEY_IDX_W-1:0];
                REG_LIFE_STATE: life_state_reg    <= cfg_wdata[LIFE_W-1:0];
                REG_TRUE_CODE:  true_code_reg     <= cfg_wdata[CODE_W-1:0];
                REG_VALID_0:    valid_word_reg[0] <= cfg_wdata[VWORD_W-1:0];
                REG_VALID_1:    valid_word_reg[1] <= cfg_wdata[VWORD_W-1:0];
                REG_VALID_2:    valid_word_reg[2] <= cfg_wdata[VWORD_W-1:0];
                REG_VALID_3:    valid_word_reg[3] <= cfg_wdata[VWORD_W-1:0];
            endcase
        end
    end

    // Effective key count and walk start index
    assign n_eff      = (key_count_reg > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : key_count_reg;
    assign start_prod = (RND_W+CNT_W)'(random_word) * (RND_W+CNT_W)'(n_eff);
    assign start_idx  = start_prod[RND_W +: KEY_IDX_W];

    assign accept    = in_valid && in_ready;
    assign lookup_go = accept && (kind == KIND_LOOKUP);

    // Next walk index, wrapped once
    assign step_sum  = CNT_W'(addr_reg) + CNT_W'(walk_step_reg);
    assign step_wrap = (step_sum >= n_reg) ? (step_sum - n_reg) : step_sum;
    assign step_bad  = (step_wrap >= n_reg);

    assign walk_over = ((remain_reg == '0) || fault_reg) && !p_vld_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEL_IDLE:
            begin
                if (lookup_go)
                begin
                    state_next = (n_eff == '0) ? SEL_DONE : SEL_WALK;
                end
            end
            SEL_WALK:
            begin
                if (walk_over)
                begin
                    state_next = SEL_DONE;
                end
            end
            SEL_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = SEL_IDLE;
                end
            end
            default: state_next = SEL_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            SEL_IDLE: in_ready = 1'b1;
            SEL_WALK: issue    = (remain_reg != '0) && !fault_reg;
            SEL_DONE: load_out = !out_valid_reg || out_ready;
            default:  in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Write entries and read one entry per walk step
    always_ff @(posedge clk)
    begin
        if (accept && (kind == KIND_WRITE))
        begin
            key_mem[entry_index] <= {key_class, key_id};
        end
        if (issue)
        begin
            rdata_reg <= key_mem[addr_reg];
        end
    end

    // Policy check on the entry read last cycle
    assign id_match = (rdata_reg[ID_W-1:0] == id_reg);
    assign vbyte    = valid_word_reg[p_idx_reg[KEY_IDX_W-1:2]][{p_idx_reg[1:0], 3'b000} +: CODE_W];
    assign verdict  = judge(rdata_reg[ENTRY_W-1:ID_W], life_state_reg, vbyte == true_code_reg);

    // Walk address, counter and lookup payload
    always_ff @(posedge clk)
    begin
        if (lookup_go)
        begin
            addr_reg <= start_idx;
            n_reg    <= n_eff;
            id_reg   <= key_id;
        end
        else if (issue)
        begin
            addr_reg <= step_wrap[KEY_IDX_W-1:0];
        end
        if (issue)
        begin
            p_idx_reg <= addr_reg;
        end
    end

    // Walk control and candidate tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            p_vld_reg  <= 1'b0;
            fault_reg  <= 1'b0;
            have_reg   <= 1'b0;
            cand_reg   <= '0;
        end
        else if (lookup_go)
        begin
            remain_reg <= n_eff;
            p_vld_reg  <= 1'b0;
            fault_reg  <= 1'b0;
            have_reg   <= 1'b0;
            cand_reg   <= '0;
        end
        else
        begin
            p_vld_reg <= issue;
            if (issue)
            begin
                remain_reg <= remain_reg - CNT_W'(1);
            end
            if ((issue && step_bad) || (p_vld_reg && id_match && verdict == ST_FAULT))
            begin
                fault_reg <= 1'b1;
            end
            if (p_vld_reg && id_match && verdict == ST_OK)
            begin
                have_reg <= 1'b1;
                cand_reg <= p_idx_reg;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (fault_reg)
            begin
                status_reg <= ST_FAULT;
                chosen_reg <= '0;
            end
            else if (have_reg)
            begin
                status_reg <= ST_OK;
                chosen_reg <= cand_reg;
            end
            else
            begin
                status_reg <= ST_BAD;
                chosen_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_index = chosen_reg;

endmodule
